// ===== src/ppghb_pkg.sv =====
// Shared types, constants and the FIR tap weights of the heart beat detector.
package ppghb_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DC,
    S_LOAD,
    S_TAPS,
    S_DRAIN,
    S_DETECT,
    S_BPM,
    S_RING,
    S_SUM,
    S_AVG,
    S_DONE
  } state_t;

  localparam int LINE_DEPTH = 32;
  localparam int LINE_AW    = 5;

  // Read order over the delay line: even slots walk back from the newest
  // sample, odd slots walk forward from the oldest, the last slot is the center.
  localparam logic [4:0] TAP_LAST_READ = 5'd22;
  localparam logic [3:0] TAP_CENTER    = 4'd11;
  localparam logic [4:0] TAP_PAIR_OFS  = 5'd10;

  localparam int DC_SHIFT = 4;

  localparam logic signed [16:0] SWING_MIN = 17'sd20;
  localparam logic signed [16:0] SWING_MAX = 17'sd1000;

  localparam int          DIV_W   = 16;
  localparam logic [15:0] BPM_NUM = 16'd60000;
  localparam logic [15:0] BPM_MIN = 16'd20;
  localparam logic [15:0] BPM_MAX = 16'd255;

  function automatic logic [12:0] tap_weight(input logic [3:0] idx);
    logic [12:0] w;
    case (idx)
      4'd0:    w = 13'd172;
      4'd1:    w = 13'd321;
      4'd2:    w = 13'd579;
      4'd3:    w = 13'd927;
      4'd4:    w = 13'd1360;
      4'd5:    w = 13'd1858;
      4'd6:    w = 13'd2390;
      4'd7:    w = 13'd2916;
      4'd8:    w = 13'd3391;
      4'd9:    w = 13'd3768;
      4'd10:   w = 13'd4012;
      4'd11:   w = 13'd4096;
      default: w = 13'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== src/ppg_heart_beat_detector_unit.sv =====
// Top level of the optical heart beat detector: DC removal, FIR, beat logic, rate ring.
//
//  Channel  Direction  Ports                          Contents
//  in_      slave      in_tvalid/in_tready/in_tdata   sample [15:0], time_ms [47:16]
//  out_     master     out_tvalid/out_tready/out_tdata/out_tuser
//                                                     rate_bpm [15:0], average_bpm [23:16];
//                                                     tuser = beat
//
// One sample is taken per transfer, and one result transfer follows each sample.
// A new sample is taken only once the last one is through the sequencer; the FIR
// part of the work is the 23 reads of the delay line through the single read port
// of its RAM, feeding one shared multiplier. A beat adds a run of the radix-2 divider
// for 60000/interval, and a rate that enters the ring adds the ring sum and its mean.
// Reset is synchronous and active low; the delay line uses per-entry valid bits,
// so there is no clearing pass and samples are taken right after reset.
// A result waits in the output register while a new sample is already being
// worked on; the block stalls only in its last state if that register is still full.
module ppg_heart_beat_detector_unit
  import ppghb_pkg::*;
#(
  parameter int RATE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // sample [15:0], time_ms [47:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // rate_bpm [15:0], average_bpm [23:16]
  output logic        out_tuser   // beat [0]
);

  // Ring index width and ring sum width follow from the ring depth.
  localparam int IDX_W = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
  localparam int SUM_W = 8 + $clog2(RATE_DEPTH);

  // The ring mean is a multiply by the rounded-up reciprocal of the depth. The shift
  // keeps enough fraction bits for the quotient to be exact over every possible sum.
  localparam int AVG_SHIFT = SUM_W + $clog2(RATE_DEPTH);
  localparam int AVG_RECIP = ((1 << AVG_SHIFT) + RATE_DEPTH - 1) / RATE_DEPTH;
  localparam int AVG_PW    = SUM_W + AVG_SHIFT + 1;

  // Sequencer state.
  state_t state_r, state_nxt;

  // Captured input item.
  logic [15:0] sample_r, sample_nxt;
  logic [31:0] time_r, time_nxt;

  // Leaky DC estimate with 15 fraction bits.
  logic [31:0] acc_r, acc_nxt;

  // Delay line control: write pointer and per-entry valid bits.
  logic [LINE_AW-1:0]    wp_r, wp_nxt;
  logic [LINE_DEPTH-1:0] vld_r, vld_nxt;

  // FIR read sequencer and its three-stage multiply-accumulate pipeline.
  logic [4:0]         tap_cnt_r, tap_cnt_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [4:0]         rd_idx_r, rd_idx_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic signed [15:0] a_r, a_nxt;
  logic signed [15:0] pair_r, pair_nxt;
  logic [3:0]         pair_idx_r, pair_idx_nxt;
  logic               pair_vld_r, pair_vld_nxt;
  logic signed [29:0] prod_r, prod_nxt;
  logic               prod_vld_r, prod_vld_nxt;
  logic signed [31:0] z_r, z_nxt;

  // Zero-crossing tracker.
  logic signed [15:0] ac_r, ac_nxt;
  logic signed [15:0] peak_r, peak_nxt;
  logic signed [15:0] trough_r, trough_nxt;
  logic               rising_r, rising_nxt;
  logic               falling_r, falling_nxt;

  // Beat timing and held results.
  logic [31:0] last_time_r, last_time_nxt;
  logic [15:0] held_bpm_r, held_bpm_nxt;
  logic [7:0]  held_avg_r, held_avg_nxt;
  logic        beat_r, beat_nxt;

  // Rate ring and its sequential sum.
  logic [7:0]       ring_r [RATE_DEPTH];
  logic [7:0]       ring_nxt [RATE_DEPTH];
  logic [IDX_W-1:0] ring_idx_r, ring_idx_nxt;
  logic [IDX_W-1:0] sum_cnt_r, sum_cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  // Restoring divider.
  logic [31:0]      div_rem_r, div_rem_nxt;
  logic [DIV_W-1:0] div_dq_r, div_dq_nxt;
  logic [31:0]      div_den_r, div_den_nxt;
  logic [4:0]       div_cnt_r, div_cnt_nxt;

  // Output register.
  logic        out_tvalid_r, out_tvalid_nxt;
  logic        out_beat_r, out_beat_nxt;
  logic [15:0] out_bpm_r, out_bpm_nxt;
  logic [7:0]  out_avg_r, out_avg_nxt;

  // RAM port signals and decoded controls.
  logic               ram_we;
  logic [LINE_AW-1:0] ram_raddr;
  logic [15:0]        ram_wdata;
  logic [15:0]        ram_q;
  logic               out_load;

  // Combinational helpers.
  logic signed [32:0] dc_diff;
  logic signed [32:0] dc_step;
  logic [32:0]        dc_sum;
  logic [3:0]         tap_half;
  logic signed [15:0] rd_data;
  logic signed [15:0] ac_new;
  logic               cross_up;
  logic               cross_dn;
  logic signed [16:0] swing;
  logic               beat_det;
  logic [31:0]        delta;
  logic [32:0]        div_t;
  logic [32:0]        div_diff;
  logic               div_ge;
  logic               bpm_in_band;
  logic               sum_last;
  logic [SUM_W-1:0]   sum_add;
  logic [AVG_PW-1:0]  avg_prod;

  ppghb_ram #(
    .WIDTH (16),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Arithmetic shared by the states.
  always_comb begin
    // The DC estimate moves one sixteenth of the way toward the sample, rounded down.
    dc_diff = $signed({2'b00, sample_r, 15'b0}) - $signed({1'b0, acc_r});
    dc_step = dc_diff >>> DC_SHIFT;
    dc_sum  = 33'($signed({1'b0, acc_r}) + dc_step);

    // Even read slots step back from the newest entry, odd ones forward from the oldest.
    tap_half = tap_cnt_r[4:1];
    if (tap_cnt_r[0]) begin
      ram_raddr = wp_r + TAP_PAIR_OFS + {1'b0, tap_half};
    end else begin
      ram_raddr = wp_r - {1'b0, tap_half};
    end

    // Entries never written read as zero.
    rd_data = rd_ok_r ? $signed(ram_q) : 16'sd0;

    // Filtered value is the tap sum shifted down by 15, wrapped to 16 bits.
    ac_new   = z_r[30:15];
    cross_up = ac_r[15] && !ac_new[15];
    cross_dn = (!ac_r[15] && (ac_r != 16'sd0)) && (ac_new[15] || (ac_new == 16'sd0));
    swing    = {peak_r[15], peak_r} - {trough_r[15], trough_r};
    beat_det = cross_up && (swing > SWING_MIN) && (swing < SWING_MAX);
    delta    = time_r - last_time_r;

    // One restoring divider step: shift in one dividend bit, subtract if it fits.
    div_t    = {div_rem_r, div_dq_r[DIV_W-1]};
    div_diff = div_t - {1'b0, div_den_r};
    div_ge   = (div_t >= {1'b0, div_den_r});

    bpm_in_band = (div_dq_r > BPM_MIN) && (div_dq_r < BPM_MAX);
    sum_last    = (sum_cnt_r == IDX_W'(RATE_DEPTH - 1));
    sum_add     = sum_r + SUM_W'(ring_r[sum_cnt_r]);
    avg_prod    = AVG_PW'(sum_r) * AVG_PW'(AVG_RECIP);
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_DC;
        end
      end
      S_DC:   state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_TAPS;
      S_TAPS: begin
        if (tap_cnt_r == TAP_LAST_READ) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_r && !pair_vld_r && !prod_vld_r) begin
          state_nxt = S_DETECT;
        end
      end
      S_DETECT: begin
        if (beat_det && (delta != 32'd0)) begin
          state_nxt = S_BPM;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_BPM: begin
        if (div_cnt_r == 5'd0) begin
          state_nxt = bpm_in_band ? S_RING : S_DONE;
        end
      end
      S_RING: state_nxt = S_SUM;
      S_SUM: begin
        if (sum_last) begin
          state_nxt = S_AVG;
        end
      end
      S_AVG:  state_nxt = S_DONE;
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Decoded controls of the sequencer.
  always_comb begin
    in_tready = (state_r == S_IDLE);
    ram_we    = (state_r == S_LOAD);
    ram_wdata = sample_r - acc_r[30:15];
    out_load  = (state_r == S_DONE) && (!out_tvalid_r || out_tready);
  end

  // Datapath next values.
  always_comb begin
    sample_nxt    = sample_r;
    time_nxt      = time_r;
    acc_nxt       = acc_r;
    wp_nxt        = wp_r;
    vld_nxt       = vld_r;
    tap_cnt_nxt   = tap_cnt_r;
    rd_vld_nxt    = (state_r == S_TAPS);
    rd_idx_nxt    = tap_cnt_r;
    rd_ok_nxt     = vld_r[ram_raddr];
    a_nxt         = a_r;
    pair_nxt      = pair_r;
    pair_idx_nxt  = pair_idx_r;
    pair_vld_nxt  = 1'b0;
    prod_nxt      = 30'(pair_r) * 30'($signed({1'b0, tap_weight(pair_idx_r)}));
    prod_vld_nxt  = pair_vld_r;
    z_nxt         = z_r;
    ac_nxt        = ac_r;
    peak_nxt      = peak_r;
    trough_nxt    = trough_r;
    rising_nxt    = rising_r;
    falling_nxt   = falling_r;
    last_time_nxt = last_time_r;
    held_bpm_nxt  = held_bpm_r;
    held_avg_nxt  = held_avg_r;
    beat_nxt      = beat_r;
    ring_nxt      = ring_r;
    ring_idx_nxt  = ring_idx_r;
    sum_cnt_nxt   = sum_cnt_r;
    sum_nxt       = sum_r;
    div_rem_nxt   = div_rem_r;
    div_dq_nxt    = div_dq_r;
    div_den_nxt   = div_den_r;
    div_cnt_nxt   = div_cnt_r;

    // Pipeline stage one pairs the symmetric taps; the center tap stands alone.
    if (rd_vld_r) begin
      if (rd_idx_r[0]) begin
        pair_nxt     = a_r + rd_data;
        pair_idx_nxt = rd_idx_r[4:1];
        pair_vld_nxt = 1'b1;
      end else if (rd_idx_r == TAP_LAST_READ) begin
        pair_nxt     = rd_data;
        pair_idx_nxt = TAP_CENTER;
        pair_vld_nxt = 1'b1;
      end else begin
        a_nxt = rd_data;
      end
    end

    // Pipeline stage three accumulates the weighted pair.
    if (prod_vld_r) begin
      z_nxt = z_r + 32'(prod_r);
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          sample_nxt = in_tdata[15:0];
          time_nxt   = in_tdata[47:16];
        end
      end
      S_DC: begin
        acc_nxt  = dc_sum[31:0];
        beat_nxt = 1'b0;
      end
      S_LOAD: begin
        vld_nxt[wp_r] = 1'b1;
        tap_cnt_nxt   = 5'd0;
        z_nxt         = 32'sd0;
      end
      S_TAPS: begin
        tap_cnt_nxt = tap_cnt_r + 5'd1;
      end
      S_DETECT: begin
        ac_nxt = ac_new;
        wp_nxt = wp_r + 5'd1;
        if (cross_up) begin
          rising_nxt  = 1'b1;
          falling_nxt = 1'b0;
        end else if (cross_dn) begin
          rising_nxt  = 1'b0;
          falling_nxt = 1'b1;
        end
        if (cross_up) begin
          peak_nxt = 16'sd0;
        end
        if (cross_dn) begin
          trough_nxt = 16'sd0;
        end
        if ((cross_up || (rising_r && !cross_dn)) && (ac_new > ac_r)) begin
          peak_nxt = ac_new;
        end
        if ((cross_dn || (falling_r && !cross_up)) && (ac_new < ac_r)) begin
          trough_nxt = ac_new;
        end
        if (beat_det) begin
          last_time_nxt = time_r;
          if (delta != 32'd0) begin
            beat_nxt    = 1'b1;
            div_rem_nxt = 32'd0;
            div_dq_nxt  = BPM_NUM;
            div_den_nxt = delta;
            div_cnt_nxt = 5'(DIV_W);
          end
        end
      end
      S_BPM: begin
        if (div_cnt_r != 5'd0) begin
          div_rem_nxt = div_ge ? div_diff[31:0] : div_t[31:0];
          div_dq_nxt  = {div_dq_r[DIV_W-2:0], div_ge};
          div_cnt_nxt = div_cnt_r - 5'd1;
        end else begin
          held_bpm_nxt = div_dq_r;
        end
      end
      S_RING: begin
        ring_nxt[ring_idx_r] = held_bpm_r[7:0];
        if (ring_idx_r == IDX_W'(RATE_DEPTH - 1)) begin
          ring_idx_nxt = '0;
        end else begin
          ring_idx_nxt = ring_idx_r + IDX_W'(1);
        end
        sum_nxt     = '0;
        sum_cnt_nxt = '0;
      end
      S_SUM: begin
        sum_nxt = sum_add;
        if (!sum_last) begin
          sum_cnt_nxt = sum_cnt_r + IDX_W'(1);
        end
      end
      S_AVG: begin
        held_avg_nxt = avg_prod[AVG_SHIFT +: 8];
      end
      default: begin
      end
    endcase
  end

  // Output register next values.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_beat_nxt   = out_beat_r;
    out_bpm_nxt    = out_bpm_r;
    out_avg_nxt    = out_avg_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
      out_beat_nxt   = beat_r;
      out_bpm_nxt    = held_bpm_r;
      out_avg_nxt    = held_avg_r;
    end
  end

  // State registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      acc_r        <= 32'd0;
      wp_r         <= '0;
      vld_r        <= '0;
      rd_vld_r     <= 1'b0;
      pair_vld_r   <= 1'b0;
      prod_vld_r   <= 1'b0;
      ac_r         <= 16'sd0;
      peak_r       <= 16'sd0;
      trough_r     <= 16'sd0;
      rising_r     <= 1'b0;
      falling_r    <= 1'b0;
      last_time_r  <= 32'd0;
      held_bpm_r   <= 16'd0;
      held_avg_r   <= 8'd0;
      beat_r       <= 1'b0;
      ring_idx_r   <= '0;
      div_cnt_r    <= 5'd0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < RATE_DEPTH; i++) begin
        ring_r[i] <= 8'd0;
      end
    end else begin
      state_r      <= state_nxt;
      acc_r        <= acc_nxt;
      wp_r         <= wp_nxt;
      vld_r        <= vld_nxt;
      rd_vld_r     <= rd_vld_nxt;
      pair_vld_r   <= pair_vld_nxt;
      prod_vld_r   <= prod_vld_nxt;
      ac_r         <= ac_nxt;
      peak_r       <= peak_nxt;
      trough_r     <= trough_nxt;
      rising_r     <= rising_nxt;
      falling_r    <= falling_nxt;
      last_time_r  <= last_time_nxt;
      held_bpm_r   <= held_bpm_nxt;
      held_avg_r   <= held_avg_nxt;
      beat_r       <= beat_nxt;
      ring_idx_r   <= ring_idx_nxt;
      div_cnt_r    <= div_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      ring_r       <= ring_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    time_r     <= time_nxt;
    tap_cnt_r  <= tap_cnt_nxt;
    rd_idx_r   <= rd_idx_nxt;
    rd_ok_r    <= rd_ok_nxt;
    a_r        <= a_nxt;
    pair_r     <= pair_nxt;
    pair_idx_r <= pair_idx_nxt;
    prod_r     <= prod_nxt;
    z_r        <= z_nxt;
    sum_cnt_r  <= sum_cnt_nxt;
    sum_r      <= sum_nxt;
    div_rem_r  <= div_rem_nxt;
    div_dq_r   <= div_dq_nxt;
    div_den_r  <= div_den_nxt;
    out_beat_r <= out_beat_nxt;
    out_bpm_r  <= out_bpm_nxt;
    out_avg_r  <= out_avg_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_avg_r, out_bpm_r};
  assign out_tuser  = out_beat_r;

`ifndef SYNTHESIS
  // A new result is only loaded from the final state of the sequencer.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == S_DONE)
    else $error("result loaded outside the final state");

  // The ring write index stays inside the ring.
  a_ring_idx: assert property (@(posedge clk) disable iff (!rst_n)
    ring_idx_r <= IDX_W'(RATE_DEPTH - 1))
    else $error("ring index out of range");

  // The FIR pipeline is empty whenever a sample is being taken.
  a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !rd_vld_r && !pair_vld_r && !prod_vld_r)
    else $error("FIR pipeline busy while idle");

  // A reported mean never exceeds the largest rate the ring accepts.
  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> out_avg_r != 8'd255)
    else $error("average out of range");

  // The divider never runs longer than its dividend width.
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    div_cnt_r <= 5'(DIV_W))
    else $error("divider step count out of range");
`endif

endmodule

// ===== src/ppghb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ppghb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== test/tb_ppg_heart_beat_detector_unit.sv =====
// Self-checking testbench for the optical heart beat detector with its own beat predictor.
module tb_ppg_heart_beat_detector_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH     = 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 100;

  // Expected contents of one result transfer.
  typedef struct packed {
    logic        beat;
    logic [15:0] rate;
    logic [7:0]  average;
  } rate_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;    // sample [15:0], time_ms [47:16]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // rate_bpm [15:0], average_bpm [23:16]
  logic        out_tuser;        // beat [0]

  ppg_heart_beat_detector_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #6 clk = ~clk;

  // Predicted state of the detector.
  int          fir_weight [12] = '{172, 321, 579, 927, 1360, 1858, 2390, 2916, 3391, 3768,
                                   4012, 4096};
  longint      dc_level_acc;
  logic [15:0] fir_line [32];
  logic [4:0]  fir_wr_ptr;
  int          ac_now;
  int          ac_last;
  int          swing_hi;
  int          swing_lo;
  int          half_peak;
  int          half_trough;
  logic        in_rise;
  logic        in_fall;
  logic [7:0]  bpm_ring [RING_DEPTH];
  logic [1:0]  bpm_ring_idx;
  logic [31:0] last_beat_ms;
  logic [31:0] held_rate;
  logic [7:0]  held_mean;

  rate_result_t expected_results [$];
  rate_result_t oldest_expected;

  int errors = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int beat_count = 0;
  int ring_entries = 0;
  int out_of_band = 0;
  int zero_intervals = 0;
  int zero_rates = 0;
  int quiet_cycles = 0;

  // Idle and stall rates in percent; changed between phases of the run.
  int send_idle_pct = 8;
  int stall_pct = 65;

  // Free-running millisecond clock that the sample tasks advance.
  logic [31:0] t_now = '0;

  function automatic int sx16(input logic [15:0] v);
    return int'($signed(v));
  endfunction

  function automatic void clear_predictor();
    dc_level_acc = 0;
    foreach (fir_line[i]) fir_line[i] = '0;
    fir_wr_ptr   = '0;
    ac_now       = 0;
    ac_last      = 0;
    swing_hi     = 20;
    swing_lo     = -20;
    half_peak    = 0;
    half_trough  = 0;
    in_rise      = 1'b0;
    in_fall      = 1'b0;
    foreach (bpm_ring[i]) bpm_ring[i] = '0;
    bpm_ring_idx = '0;
    last_beat_ms = '0;
    held_rate    = '0;
    held_mean    = '0;
  endfunction

  // Runs one sample through DC removal, the FIR, crossing detection and the
  // rate logic, and returns the result the block should send for it.
  function automatic rate_result_t predict_beat(input logic [15:0] s, input logic [31:0] t);
    rate_result_t r;
    longint target;
    longint acc;
    int level;
    int swing;
    int ring_sum;
    logic [4:0] ia;
    logic [4:0] ib;
    logic [31:0] delta;
    logic hit;
    hit = 1'b0;
    ac_last = ac_now;

    // Leaky DC estimate with a 1/16 step; the floor division is an arithmetic shift.
    target = longint'(s) * 32768;
    dc_level_acc = dc_level_acc + ((target - dc_level_acc) >>> 4);
    level = int'(dc_level_acc >>> 15);

    // Symmetric FIR: pairs are summed and wrapped to 16 bits before the multiply.
    fir_line[fir_wr_ptr] = 16'(int'(s) - level);
    ia = fir_wr_ptr - 5'd11;
    acc = longint'(fir_weight[11]) * longint'(sx16(fir_line[ia]));
    for (int i = 0; i < 11; i++) begin
      ia = fir_wr_ptr - 5'(i);
      ib = fir_wr_ptr - 5'd22 + 5'(i);
      acc = acc + longint'(fir_weight[i]) *
            longint'(sx16(16'(sx16(fir_line[ia]) + sx16(fir_line[ib]))));
    end
    fir_wr_ptr = fir_wr_ptr + 5'd1;
    ac_now = sx16(16'(acc >>> 15));

    // A rising zero crossing closes one cycle; its swing decides the beat.
    if (ac_last < 0 && ac_now >= 0) begin
      swing_hi  = half_peak;
      swing_lo  = half_trough;
      in_rise   = 1'b1;
      in_fall   = 1'b0;
      half_peak = 0;
      swing = swing_hi - swing_lo;
      if (swing > 20 && swing < 1000) hit = 1'b1;
    end
    if (ac_last > 0 && ac_now <= 0) begin
      in_rise     = 1'b0;
      in_fall     = 1'b1;
      half_trough = 0;
    end
    if (in_rise && ac_now > ac_last) half_peak = ac_now;
    if (in_fall && ac_now < ac_last) half_trough = ac_now;

    r.beat = 1'b0;
    if (hit) begin
      // The interval wraps with the millisecond clock.
      delta = t - last_beat_ms;
      last_beat_ms = t;
      if (delta == 0) begin
        zero_intervals++;
      end else begin
        held_rate = 32'd60000 / delta;
        if (held_rate < 255 && held_rate > 20) begin
          bpm_ring[bpm_ring_idx] = held_rate[7:0];
          bpm_ring_idx = bpm_ring_idx + 2'd1;
          ring_sum = 0;
          foreach (bpm_ring[k]) ring_sum += bpm_ring[k];
          held_mean = 8'(ring_sum / RING_DEPTH);
          ring_entries++;
        end else begin
          out_of_band++;
        end
        if (held_rate == 0) zero_rates++;
        beat_count++;
        r.beat = 1'b1;
      end
    end
    r.rate    = held_rate[15:0];
    r.average = held_mean;
    return r;
  endfunction

  // Offers one sample, waits for its transfer and records the expected result.
  task automatic send_sample(input logic [15:0] s, input logic [31:0] t);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t, s};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_beat(s, t));
    samples_sent++;
  endtask

  // Holds the input channel until every result sent so far has come back.
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Sends a triangle pulse train on a DC base; the clock advances by step plus
  // up to jitter milliseconds per sample.
  task automatic send_rhythm(input int count, input int period, input int amp, input int base,
                             input int step, input int jitter, input int noise);
    int pos;
    int half;
    int wave;
    int level;
    half = period / 2;
    for (int k = 0; k < count; k++) begin
      pos = k % period;
      if (pos < half) wave = -amp + (2 * amp * pos) / half;
      else wave = amp - (2 * amp * (pos - half)) / (period - half);
      level = base + wave;
      if (noise > 0) level = level + int'($urandom_range(0, 2 * noise)) - noise;
      if (level < 0) level = 0;
      if (level > 65535) level = 65535;
      send_sample(16'(level), t_now);
      t_now = t_now + 32'(step) + $urandom_range(0, jitter);
    end
  endtask

  // Picks a random pulse shape and sends it.
  task automatic send_random_rhythm(input int count, input int step, input int jitter);
    int amp;
    int noise;
    amp   = $urandom_range(8, 900);
    noise = $urandom_range(0, amp / 8);
    send_rhythm(count, $urandom_range(10, 60), amp,
                $urandom_range(amp + noise, 65535 - amp - noise), step, jitter, noise);
  endtask

  // The first beat after reset measures its interval from time zero.
  task automatic test_first_beat();
    t_now = 32'd0;
    send_rhythm(100, 30, 300, 20000, 20, 0, 0);
  endtask

  // Extremes and walking patterns of both input fields.
  task automatic test_field_extremes();
    send_sample(16'h0000, 32'h0000_0000);
    send_sample(16'hFFFF, 32'hFFFF_FFFF);
    send_sample(16'h0000, 32'hFFFF_FFFF);
    send_sample(16'hFFFF, 32'h0000_0000);
    send_sample(16'hAAAA, 32'hAAAA_AAAA);
    send_sample(16'h5555, 32'h5555_5555);
    send_sample(16'h8000, 32'h8000_0000);
    send_sample(16'h7FFF, 32'h7FFF_FFFF);
    send_sample(16'h0001, 32'h0000_0001);
    send_sample(16'hFFFE, 32'hFFFF_FFFE);
    for (int k = 0; k < 10; k++) send_sample(k[0] ? 16'hFFFF : 16'h0000, 32'(k * 7));
    t_now = 32'd1000;
  endtask

  // The rhythm starts with the millisecond clock 4096 ms below its wrap through zero.
  task automatic test_clock_wrap();
    t_now = 32'hFFFF_F000;
    send_rhythm(150, 28, 250, 30000, 25, 3, 4);
  endtask

  // The clock stands still, so beats after the first one have a zero interval.
  task automatic test_zero_interval();
    send_rhythm(120, 24, 200, 12000, 0, 0, 0);
  endtask

  // Long steps give intervals above 60000 ms (rate zero) and rates of 20 or less.
  task automatic test_long_interval();
    send_rhythm(80, 30, 350, 40000, 2500, 0, 0);
    send_rhythm(70, 20, 350, 40000, 150, 20, 0);
  endtask

  // Short steps give rates near and above 255; those of 255 and more stay out of the ring.
  task automatic test_rate_band();
    send_rhythm(60, 14, 200, 25000, 8, 0, 0);
    send_rhythm(60, 16, 200, 25000, 15, 0, 2);
  endtask

  // The sender stops until the block has returned every result, then resumes.
  task automatic test_drain_pause();
    send_random_rhythm(30, 20, 5);
    hold_until_drained();
    send_random_rhythm(30, 20, 5);
  endtask

  // Mostly pulse trains with random shape and timing, with bursts of raw noise,
  // odd clock steps and pauses in between. The idle pattern changes by thirds.
  task automatic test_random_rhythms(input int goal);
    int start;
    int done;
    int kind;
    start = samples_sent;
    done  = 0;
    while (done < goal) begin
      if (done < goal / 3) begin
        send_idle_pct = 8;
        stall_pct     = 65;
      end else if (done < 2 * goal / 3) begin
        send_idle_pct = 65;
        stall_pct     = 8;
      end else begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        send_random_rhythm($urandom_range(40, 160), $urandom_range(4, 60),
                           $urandom_range(0, 15));
      end else if (kind < 90) begin
        // Raw noise, with the clock either jumping anywhere or moving on.
        repeat ($urandom_range(5, 20)) begin
          if ($urandom_range(0, 1)) t_now = $urandom();
          else t_now = t_now + $urandom_range(0, 1000);
          send_sample(16'($urandom_range(0, 65535)), t_now);
        end
      end else if (kind < 96) begin
        case ($urandom_range(0, 3))
          0:       send_random_rhythm(60, 0, 0);
          1:       send_random_rhythm(60, 1, 1);
          2:       send_random_rhythm(60, 3000, 0);
          default: send_random_rhythm(60, 40000, 5000);
        endcase
      end else begin
        hold_until_drained();
        send_random_rhythm($urandom_range(20, 60), $urandom_range(10, 40), 2);
      end
      done = samples_sent - start;
    end
  endtask

  // Result side: random back-pressure and a field-by-field check of every transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with no sample waiting: beat=%0b rate=%0d average=%0d",
                   $time, out_tuser, out_tdata[15:0], out_tdata[23:16]);
          errors++;
        end else begin
          oldest_expected = expected_results.pop_front();
          if (out_tuser !== oldest_expected.beat) begin
            $display("%0t: beat mismatch: expected %0b, actual %0b",
                     $time, oldest_expected.beat, out_tuser);
            errors++;
          end
          if (out_tdata[15:0] !== oldest_expected.rate) begin
            $display("%0t: rate_bpm mismatch: expected %0d, actual %0d",
                     $time, oldest_expected.rate, out_tdata[15:0]);
            errors++;
          end
          if (out_tdata[23:16] !== oldest_expected.average) begin
            $display("%0t: average_bpm mismatch: expected %0d, actual %0d",
                     $time, oldest_expected.average, out_tdata[23:16]);
            errors++;
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Ends the run if neither channel has moved a transfer for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    clear_predictor();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_beat();
    test_field_extremes();
    test_clock_wrap();
    test_zero_interval();
    test_long_interval();
    test_rate_band();
    test_drain_pause();
    test_random_rhythms(1050);

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples and checked %0d results, under three idle patterns.",
             samples_sent, results_seen);
    $display("Beats %0d: %0d into the rate ring, %0d out of band (%0d at rate zero), %0d zero intervals.",
             beat_count, ring_entries, out_of_band, zero_rates, zero_intervals);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
